@@ hw/rtl/lud_pkg.sv @@
// lud_pkg: shared types and constants for the lu decomposition unit
// depends on nothing
package lud_pkg;
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PIV_RD,
        ST_PIV_WT,
        ST_L_RD,
        ST_L_WT,
        ST_DIV,
        ST_L_WR,
        ST_J_RD,
        ST_J_WT,
        ST_MUL,
        ST_SUB,
        ST_OUT_RD,
        ST_OUT_WT
    } lud_state_t;

    localparam int unsigned DataW = 32;
    localparam int unsigned FracW = 16;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction
endpackage

@@ hw/rtl/lu_decomposition_unit.sv @@
// lu_decomposition_unit: loads an n by n q16.16 matrix and factors it in place
// depends on lud_pkg, lud_ram, lud_divider
// An item is one matrix element; the block takes one per cycle while loading. After the
// last element busy rises for the factorization: each multiplier is computed in the
// bit-serial divider and each update of an entry goes through the single ram port,
// then the n*n results leave in row order (single failure word on a zero pivot).
// The receiver cannot stall: each result shows for one cycle with result_valid.
module lu_decomposition_unit #(
    parameter int MaxOrder = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] element_value,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata,
    output logic               result_valid,
    output logic [2:0]         row_index,
    output logic [2:0]         col_index,
    output logic signed [31:0] factor_value,
    output logic               status,
    output logic               last_of_run
);
    import lud_pkg::*;

    localparam int Depth = MaxOrder * MaxOrder;
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    lud_state_t state_reg, state_next;
    logic [3:0] size_reg;
    logic [6:0] load_reg;
    logic [3:0] n_reg, n_next;
    logic [2:0] k_reg, i_reg, j_reg;
    logic [2:0] k_next, i_next, j_next;
    logic signed [31:0] piv_reg, l_reg, p_reg;
    logic signed [63:0] prod_reg;
    logic [3:0] n_use;
    logic [7:0] total;

    logic           we;
    logic [AW-1:0]  addr;
    logic [31:0]    wdata, rdata;
    logic           div_start, div_done;
    logic signed [31:0] div_q;

    logic rv_reg, rv_next, st_reg, st_next, last_reg, last_next;
    logic [2:0] ro_reg, co_reg, ro_next, co_next;
    logic signed [31:0] fv_reg, fv_next;

    lud_ram #(.Width(32), .Depth(Depth)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    lud_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .numer(rdata), .denom(piv_reg), .done(div_done), .quot(div_q)
    );

    always_comb
    begin
        n_use = size_reg;
        if (n_use == 4'd0)
            n_use = 4'd1;
        if (n_use > 4'(MaxOrder))
            n_use = 4'(MaxOrder);
        total = 8'(n_use) * 8'(n_use);
    end

    function automatic logic [AW-1:0] idx(input logic [3:0] n, input logic [2:0] r,
                                          input logic [2:0] c);
        logic [7:0] t;
        t = 8'(r) * 8'(n) + 8'(c);
        return t[AW-1:0];
    endfunction

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;
        k_next = k_reg;
        i_next = i_reg;
        j_next = j_reg;
        case (state_reg)
            ST_LOAD:
                if (start && 8'(load_reg) + 8'd1 >= total)
                begin
                    state_next = ST_PIV_RD;
                    n_next = n_use;
                    k_next = '0;
                end
            ST_PIV_RD: state_next = ST_PIV_WT;
            ST_PIV_WT:
                if (rdata == '0)
                    state_next = ST_LOAD;
                else if (4'(k_reg) + 4'd1 >= n_reg)
                begin
                    state_next = ST_OUT_RD;
                    i_next = '0;
                    j_next = '0;
                end
                else
                begin
                    state_next = ST_L_RD;
                    i_next = k_reg + 3'd1;
                end
            ST_L_RD: state_next = ST_L_WT;
            ST_L_WT: state_next = ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = ST_L_WR;
            ST_L_WR:
            begin
                state_next = ST_J_RD;
                j_next = k_reg + 3'd1;
            end
            ST_J_RD: state_next = ST_J_WT;
            ST_J_WT: state_next = ST_MUL;
            ST_MUL: state_next = ST_SUB;
            ST_SUB:
                if (4'(j_reg) + 4'd1 < n_reg)
                begin
                    j_next = j_reg + 3'd1;
                    state_next = ST_J_RD;
                end
                else if (4'(i_reg) + 4'd1 < n_reg)
                begin
                    i_next = i_reg + 3'd1;
                    state_next = ST_L_RD;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                    state_next = ST_PIV_RD;
                end
            ST_OUT_RD: state_next = ST_OUT_WT;
            ST_OUT_WT:
                if (4'(j_reg) + 4'd1 < n_reg)
                begin
                    j_next = j_reg + 3'd1;
                    state_next = ST_OUT_RD;
                end
                else if (4'(i_reg) + 4'd1 < n_reg)
                begin
                    i_next = i_reg + 3'd1;
                    j_next = '0;
                    state_next = ST_OUT_RD;
                end
                else
                    state_next = ST_LOAD;
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        we = 1'b0;
        addr = '0;
        wdata = '0;
        div_start = 1'b0;
        rv_next = 1'b0;
        st_next = 1'b0;
        last_next = 1'b0;
        ro_next = ro_reg;
        co_next = co_reg;
        fv_next = fv_reg;
        case (state_reg)
            ST_LOAD:
            begin
                we = start;
                addr = load_reg[AW-1:0];
                wdata = element_value;
            end
            ST_PIV_RD: addr = idx(n_reg, k_reg, k_reg);
            ST_PIV_WT:
                if (rdata == '0)
                begin
                    rv_next = 1'b1;
                    st_next = 1'b1;
                    last_next = 1'b1;
                    ro_next = k_reg;
                    co_next = k_reg;
                    fv_next = '0;
                end
            ST_L_RD: addr = idx(n_reg, i_reg, k_reg);
            ST_L_WT: div_start = 1'b1;
            ST_L_WR:
            begin
                we = 1'b1;
                addr = idx(n_reg, i_reg, k_reg);
                wdata = l_reg;
            end
            ST_J_RD: addr = idx(n_reg, k_reg, j_reg);
            ST_J_WT: addr = idx(n_reg, i_reg, j_reg);
            ST_MUL: addr = idx(n_reg, i_reg, j_reg);
            ST_SUB:
            begin
                we = 1'b1;
                addr = idx(n_reg, i_reg, j_reg);
                wdata = sat32(64'($signed(rdata)) - 64'(p_reg));
            end
            ST_OUT_RD: addr = idx(n_reg, i_reg, j_reg);
            ST_OUT_WT:
            begin
                rv_next = 1'b1;
                ro_next = i_reg;
                co_next = j_reg;
                fv_next = rdata;
                last_next = (4'(i_reg) + 4'd1 >= n_reg) && (4'(j_reg) + 4'd1 >= n_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            size_reg <= 4'd8;
            load_reg <= '0;
            rv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg <= rv_next;
            if (cfg_we)
                size_reg <= cfg_wdata;
            if (state_reg == ST_LOAD && start)
                load_reg <= (state_next == ST_LOAD) ? load_reg + 7'd1 : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        k_reg <= k_next;
        i_reg <= i_next;
        j_reg <= j_next;
        st_reg <= st_next;
        last_reg <= last_next;
        ro_reg <= ro_next;
        co_reg <= co_next;
        fv_reg <= fv_next;
        if (state_reg == ST_PIV_WT)
            piv_reg <= rdata;
        if (div_done)
            l_reg <= div_q;
        if (state_reg == ST_J_WT)
            prod_reg <= 64'(l_reg) * 64'($signed(rdata));
        p_reg <= sat32((prod_reg < 0) ? -((-prod_reg) >>> FracW) : (prod_reg >>> FracW));
    end

    assign busy = (state_reg != ST_LOAD);
    assign result_valid = rv_reg;
    assign row_index = ro_reg;
    assign col_index = co_reg;
    assign factor_value = fv_reg;
    assign status = st_reg;
    assign last_of_run = last_reg;

    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status |-> last_of_run && factor_value == '0)
        else $error("failure word not final");
    a_no_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result while idle");
    a_fail_diag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status |-> row_index == col_index)
        else $error("failure off diagonal");
    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider done outside wait");
endmodule

@@ hw/rtl/lud_ram.sv @@
// lud_ram: generic single-port ram with registered read
// depends on nothing
module lud_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

@@ hw/rtl/lud_divider.sv @@
// lud_divider: restoring divider, one quotient bit per cycle, truncating toward zero
// depends on lud_pkg
module lud_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] numer,
    input  logic signed [31:0] denom,
    output logic               done,
    output logic signed [31:0] quot
);
    import lud_pkg::*;

    logic [47:0] rem_reg, rem_next;
    logic [47:0] q_reg, q_next;
    logic [31:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [48:0] trial;
    logic signed [63:0] sq;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            q_next    = {(numer[31] ? 32'(-numer) : 32'(numer)), 16'd0};
            d_next    = denom[31] ? 32'(-denom) : 32'(denom);
            neg_next  = numer[31] ^ denom[31];
            rem_next  = '0;
            cnt_next  = 6'd48;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg, q_reg[47]} - {17'd0, d_reg};
            if (!trial[48])
            begin
                rem_next = trial[47:0];
                q_next   = {q_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[46:0], q_reg[47]};
                q_next   = {q_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign sq   = neg_reg ? -$signed({16'd0, q_reg}) : $signed({16'd0, q_reg});
    assign quot = sat32(sq);
    assign done = done_reg;
endmodule

@@ sim/tb.sv @@
// tb: self-checking testbench for lu_decomposition_unit
// depends on lud_pkg and the lu decomposition rtl; drives matrices, predicts and checks every word
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lud_pkg::*;

    typedef struct packed {
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value;
        logic               fail;
        logic               last;
    } lu_word_t;

    typedef struct {
        logic [3:0]         size;
        logic signed [31:0] element;
        logic               typed;
        lu_word_t           word;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] element_value;
    logic               cfg_we;
    logic [3:0]         cfg_wdata;
    logic               result_valid;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [31:0] factor_value;
    logic               status;
    logic               last_of_run;

    lu_word_t           factor_queue[$];
    lu_word_t           fresh_words[$];
    logic signed [63:0] model_store[64];
    int unsigned        model_count;
    logic [3:0]         model_size;
    int                 errors;
    int                 words_seen;
    int                 items_sent;
    int                 matrices_done;
    int                 fail_words;
    int                 burst_left;

    lu_decomposition_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .element_value(element_value),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .row_index    (row_index),
        .col_index    (col_index),
        .factor_value (factor_value),
        .status       (status),
        .last_of_run  (last_of_run)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > 64'sh7FFF_FFFF)
            r = 64'sh7FFF_FFFF;
        else if (v < -64'sh8000_0000)
            r = -64'sh8000_0000;
        else
            r = v;
        return r;
    endfunction

    task automatic factor_element(input logic signed [31:0] val);
        int                 n;
        int                 i;
        int                 j;
        int                 k;
        logic signed [63:0] piv;
        logic signed [63:0] mult;
        logic signed [63:0] prod;
        lu_word_t           w;
        begin
            n = (model_size == 0) ? 1 : (model_size > 8) ? 8 : model_size;
            fresh_words.delete();
            model_store[model_count[5:0]] = val;
            model_count = (model_count + 1) & 127;
            if (model_count >= n * n)
            begin
                model_count = 0;
                for (k = 0; k < n; k++)
                begin
                    piv = model_store[k * n + k];
                    if (piv == 0)
                    begin
                        w = '{row: k[2:0], col: k[2:0], value: '0, fail: 1'b1, last: 1'b1};
                        fresh_words.push_back(w);
                        return;
                    end
                    for (i = k + 1; i < n; i++)
                    begin
                        mult = clip32((model_store[i * n + k] * 64'sd65536) / piv);
                        model_store[i * n + k] = mult;
                        for (j = k + 1; j < n; j++)
                        begin
                            prod = clip32((mult * model_store[k * n + j]) / 64'sd65536);
                            model_store[i * n + j] = clip32(model_store[i * n + j] - prod);
                        end
                    end
                end
                for (i = 0; i < n; i++)
                    for (j = 0; j < n; j++)
                    begin
                        w.row   = i[2:0];
                        w.col   = j[2:0];
                        w.value = model_store[i * n + j][31:0];
                        w.fail  = 1'b0;
                        w.last  = (i == n - 1) && (j == n - 1);
                        fresh_words.push_back(w);
                    end
            end
        end
    endtask

    always @(posedge clk)
    begin
        lu_word_t want;
        if (rst_n && result_valid)
        begin
            words_seen++;
            if (status)
                fail_words++;
            if (factor_queue.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word r%0d c%0d v=%h st=%b last=%b", $time,
                         row_index, col_index, factor_value, status, last_of_run);
            end
            else
            begin
                want = factor_queue.pop_front();
                if (want.row != row_index || want.col != col_index ||
                    want.value != factor_value || want.fail != status ||
                    want.last != last_of_run)
                begin
                    errors++;
                    $display("%0t: mismatch expected r%0d c%0d v=%h st=%b last=%b", $time,
                             want.row, want.col, want.value, want.fail, want.last);
                    $display("%0t:          actual   r%0d c%0d v=%h st=%b last=%b", $time,
                             row_index, col_index, factor_value, status, last_of_run);
                end
            end
        end
    end

    task automatic drain_and_settle();
        begin
            start <= 1'b0;
            while (factor_queue.size() != 0)
                @(posedge clk);
            repeat (40) @(posedge clk);
            while (busy)
                @(posedge clk);
        end
    endtask

    task automatic write_size(input logic [3:0] sz);
        begin
            drain_and_settle();
            cfg_we    <= 1'b1;
            cfg_wdata <= sz;
            @(posedge clk);
            cfg_we     <= 1'b0;
            model_size  = sz;
        end
    endtask

    task automatic send_element(input logic signed [31:0] v, input logic typed,
                                input lu_word_t word);
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                if ($urandom_range(0, 2) != 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                end
            end
            burst_left--;
            start         <= 1'b1;
            element_value <= v;
            do
                @(posedge clk);
            while (busy);
            items_sent++;
            factor_element(v);
            if (fresh_words.size() != 0)
                matrices_done++;
            if (typed && fresh_words.size() != 0)
                factor_queue.push_back(word);
            else
                foreach (fresh_words[q])
                    factor_queue.push_back(fresh_words[q]);
        end
    endtask

    function automatic logic signed [31:0] random_element(input int mode, input bit diag);
        logic signed [31:0] v;
        begin
            case (mode)
                0: begin
                    v = $signed($urandom) >>> $urandom_range(9, 15);
                    if (diag)
                        v = ($urandom_range(0, 1) ? 32'sd1 : -32'sd1) *
                            ($signed({12'd0, 4'($urandom_range(8, 15)), 16'd0}) +
                             $signed({16'd0, 16'($urandom)}));
                end
                1: v = $urandom;
                default: v = ($urandom_range(0, 2) == 0) ? 32'sd0 :
                             $signed($urandom) >>> $urandom_range(4, 14);
            endcase
            return v;
        end
    endfunction

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        stim_row_t table_rows[$];
        lu_word_t  none;
        int        r;
        int        n;
        int        e;
        int        mode;
        logic [3:0] sz;
        none          = '0;
        rst_n         = 1'b0;
        start         = 1'b0;
        element_value = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        errors        = 0;
        words_seen    = 0;
        items_sent    = 0;
        matrices_done = 0;
        fail_words    = 0;
        burst_left    = 0;
        model_count   = 0;
        model_size    = 4'd8;
        foreach (model_store[q])
            model_store[q] = '0;

        // zero pivot, extremes, size zero, late zero pivot, saturating multiplier
        table_rows = '{
            '{4'd1, 32'sh0000_0000, 1'b1, '{3'd0, 3'd0, 32'sh0, 1'b1, 1'b1}},
            '{4'd1, 32'sh7FFF_FFFF, 1'b1, '{3'd0, 3'd0, 32'sh7FFF_FFFF, 1'b0, 1'b1}},
            '{4'd1, 32'sh8000_0000, 1'b1, '{3'd0, 3'd0, 32'sh8000_0000, 1'b0, 1'b1}},
            '{4'd0, 32'sh0001_0000, 1'b1, '{3'd0, 3'd0, 32'sh0001_0000, 1'b0, 1'b1}},
            '{4'd2, 32'sh0000_0000, 1'b0, none},
            '{4'd2, 32'sh0001_0000, 1'b0, none},
            '{4'd2, 32'sh0001_0000, 1'b0, none},
            '{4'd2, 32'sh0001_0000, 1'b1, '{3'd0, 3'd0, 32'sh0, 1'b1, 1'b1}},
            '{4'd2, 32'sh0001_0000, 1'b0, none},
            '{4'd2, 32'sh0001_0000, 1'b0, none},
            '{4'd2, 32'sh0001_0000, 1'b0, none},
            '{4'd2, 32'sh0001_0000, 1'b1, '{3'd1, 3'd1, 32'sh0, 1'b1, 1'b1}},
            '{4'd2, 32'sh0001_8000, 1'b0, none},
            '{4'd2, 32'sh0002_0000, 1'b0, none},
            '{4'd2, 32'shFFFD_0000, 1'b0, none},
            '{4'd2, 32'sh0004_4000, 1'b0, none},
            '{4'd2, 32'sh0000_0001, 1'b0, none},
            '{4'd2, 32'sh7FFF_FFFF, 1'b0, none},
            '{4'd2, 32'sh8000_0000, 1'b0, none},
            '{4'd2, 32'sh7FFF_FFFF, 1'b0, none}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (r = 0; r < table_rows.size(); r++)
        begin
            if (table_rows[r].size != model_size || r == 0)
                write_size(table_rows[r].size);
            send_element(table_rows[r].element, table_rows[r].typed, table_rows[r].word);
        end

        while (items_sent < 230)
        begin
            case ($urandom_range(0, 9))
                0: sz = 4'd8;
                1: sz = ($urandom_range(0, 1) != 0) ? 4'd15 : 4'($urandom_range(9, 14));
                2: sz = 4'd0;
                default: sz = 4'($urandom_range(1, 5));
            endcase
            if (sz != model_size || $urandom_range(0, 3) == 0)
                write_size(sz);
            n    = (sz == 0) ? 1 : (sz > 8) ? 8 : sz;
            r    = $urandom_range(0, 9);
            mode = (r < 7) ? 0 : (r < 9) ? 1 : 2;
            for (e = 0; e < n * n; e++)
                send_element(random_element(mode, (e / n) == (e % n)), 1'b0, none);
        end

        drain_and_settle();
        $display("covered %0d elements in %0d matrices of order 1 to 8, size codes 0 to 15,",
                 items_sent, matrices_done);
        $display("%0d result words checked, %0d of them zero pivot reports",
                 words_seen, fail_words);
        if (errors == 0 && factor_queue.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/lud_pkg.sv
hw/rtl/lud_ram.sv
hw/rtl/lud_divider.sv
hw/rtl/lu_decomposition_unit.sv
sim/tb.sv
